// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/crc8frc_pkg.sv -----
// ----------------------------------------------------------------------------
// crc8frc_pkg
// Types, constants and the byte-wide CRC-8 update for the frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc8frc_pkg;

  // Verdict codes carried in the result word
  typedef enum logic [2:0] {
    VERDICT_CRC_ERR = 3'd0,
    VERDICT_LEN_ERR = 3'd1,
    VERDICT_ACK     = 3'd2,
    VERDICT_COLLECT = 3'd3,
    VERDICT_OTHER   = 3'd4
  } verdict_e;

  localparam logic [15:0] MaxLenReset   = 16'd2530;
  localparam logic [15:0] MinFrameLen   = 16'd5;
  localparam logic [7:0]  CrcPoly       = 8'h31;
  localparam logic [7:0]  CmdAck        = 8'hA6;
  localparam logic [7:0]  SubCollectA   = 8'h01;
  localparam logic [7:0]  SubCollectB   = 8'h11;

  // Frame byte positions with a meaning of their own
  localparam logic [15:0] PosLenHi = 16'd1;
  localparam logic [15:0] PosLenLo = 16'd2;
  localparam logic [15:0] PosCmd   = 16'd3;
  localparam logic [15:0] PosSub   = 16'd4;

  localparam int unsigned OutDataW = 40;

  // CRC-8, MSB first, no reflection, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/crc8_frame_receive_checker.sv -----
// ----------------------------------------------------------------------------
// crc8_frame_receive_checker
// Byte-serial frame checker: big-endian length in bytes 1-2, CRC-8 (0x31)
// over bytes 0..L-1 compared with byte L, at most one verdict word per frame.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid / tready        | tdata[7:0] rx_byte, tuser[0] frame_first
//  m_axis   | out | tvalid / tready        | tdata[39:0] verdict, cmd, sub, length
//  cfg      | in  | cfg_we_i (no wait)     | cfg_wdata_i[15:0] max_frame_length
//
//  One byte per cycle sustained while the result register is not stalled. A
//  word goes from an input stage register through the CRC/decode logic into
//  the result register, so a verdict is valid once its byte has passed both
//  registers, first the input stage and then the result register.
//  Reset (async, active low) clears control state; the checker then ignores
//  bytes until one arrives with frame_first set.
//  A stalled result register holds the input stage, which then throttles
//  s_axis_tready; no word is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crc8_frame_receive_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] frame_first
  // verdicts
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [crc8frc_pkg::OutDataW-1:0] m_axis_tdata
    // [2:0] verdict, [10:3] command_byte, [18:11] subcommand_byte,
    // [34:19] declared_length, [39:35] zero
);

  import crc8frc_pkg::*;

  // configuration register
  logic [15:0] max_len_q;

  // input stage
  logic        stg_valid_q;
  logic [7:0]  stg_byte_q;
  logic        stg_first_q;

  // frame state
  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  sub_q, sub_d;
  logic        done_q, done_d;

  // result register
  logic        out_valid_q, out_valid_d;
  verdict_e    out_verdict_q, out_verdict_d;
  logic [7:0]  out_cmd_q, out_cmd_d;
  logic [7:0]  out_sub_q, out_sub_d;
  logic [15:0] out_len_q, out_len_d;

  // working values
  logic        advance;
  logic        active;
  logic        res_valid;
  logic [15:0] pos_e, len_e, len_new;
  logic [7:0]  crc_e, cmd_e, sub_e;
  logic        done_e;

  // the stage moves on whenever the result register can take a word
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !stg_valid_q || advance;

  // config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stg_byte_q  <= s_axis_tdata;
      stg_first_q <= s_axis_tuser[0];
    end
  end

  // frame decode for the staged byte
  always_comb begin
    // a frame start restarts the state before this byte is looked at
    if (stg_first_q) begin
      pos_e  = '0;
      len_e  = '0;
      crc_e  = '0;
      cmd_e  = '0;
      sub_e  = '0;
      done_e = 1'b0;
    end else begin
      pos_e  = pos_q;
      len_e  = len_q;
      crc_e  = crc_q;
      cmd_e  = cmd_q;
      sub_e  = sub_q;
      done_e = done_q;
    end

    active    = stg_valid_q && advance && !done_e;
    len_new   = {len_e[15:8], stg_byte_q};
    res_valid = 1'b0;

    pos_d  = pos_q;
    len_d  = len_q;
    crc_d  = crc_q;
    cmd_d  = cmd_q;
    sub_d  = sub_q;
    done_d = done_q;

    out_verdict_d = out_verdict_q;
    out_cmd_d     = out_cmd_q;
    out_sub_d     = out_sub_q;
    out_len_d     = out_len_q;

    if (stg_valid_q && advance) begin
      pos_d  = pos_e;
      len_d  = len_e;
      crc_d  = crc_e;
      cmd_d  = cmd_e;
      sub_d  = sub_e;
      done_d = done_e;
    end

    if (active) begin
      if (pos_e >= MinFrameLen && pos_e == len_e) begin
        // check byte
        res_valid = 1'b1;
        done_d    = 1'b1;
        out_cmd_d = cmd_e;
        out_sub_d = sub_e;
        out_len_d = len_e;
        if (stg_byte_q != crc_e) begin
          out_verdict_d = VERDICT_CRC_ERR;
        end else if (cmd_e == CmdAck) begin
          out_verdict_d = VERDICT_ACK;
        end else if (sub_e == SubCollectA || sub_e == SubCollectB) begin
          out_verdict_d = VERDICT_COLLECT;
        end else begin
          out_verdict_d = VERDICT_OTHER;
        end
      end else begin
        crc_d = crc8_byte(crc_e, stg_byte_q);
        pos_d = pos_e + 16'd1;
        case (pos_e)
          PosLenHi: len_d = {stg_byte_q, 8'h00};
          PosLenLo: begin
            len_d = len_new;
            // declared length out of range ends the frame here
            if (len_new > max_len_q || len_new < MinFrameLen) begin
              res_valid     = 1'b1;
              done_d        = 1'b1;
              pos_d         = pos_e;
              out_verdict_d = VERDICT_LEN_ERR;
              out_cmd_d     = '0;
              out_sub_d     = '0;
              out_len_d     = len_new;
            end
          end
          PosCmd:  cmd_d = stg_byte_q;
          PosSub:  sub_d = stg_byte_q;
          default: ;
        endcase
      end
    end

    if (advance) begin
      out_valid_d = res_valid;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      crc_q  <= '0;
      cmd_q  <= '0;
      sub_q  <= '0;
      done_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      cmd_q  <= cmd_d;
      sub_q  <= sub_d;
      done_q <= done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_verdict_q <= out_verdict_d;
    out_cmd_q     <= out_cmd_d;
    out_sub_q     <= out_sub_d;
    out_len_q     <= out_len_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_len_q, out_sub_q, out_cmd_q, out_verdict_q};

  // checks
  `ASSERT_IMPLIES(a_len_err_no_cmd, clk_i, rst_ni,
    out_valid_q && out_verdict_q == VERDICT_LEN_ERR, out_cmd_q == 8'h00 && out_sub_q == 8'h00)
  `ASSERT_IMPLIES(a_check_len_min, clk_i, rst_ni,
    out_valid_q && out_verdict_q != VERDICT_LEN_ERR, out_len_q >= MinFrameLen)
  `ASSERT_IMPLIES(a_idle_no_result, clk_i, rst_ni,
    stg_valid_q && !stg_first_q && done_q, !res_valid)
  `ASSERT_NEXT(a_accept_staged, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, stg_valid_q)

endmodule

`default_nettype wire

// ----- test/crc8_verdict_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_verdict_checker
// Watches the byte and verdict channels of the CRC-8 frame checker, predicts
// each verdict word from the bytes and the length limit seen on the ports,
// and compares every verdict word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crc8_verdict_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]          s_axis_tuser,   // [0] frame_first
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [crc8frc_pkg::OutDataW-1:0] m_axis_tdata,
    // [2:0] verdict, [10:3] command_byte, [18:11] subcommand_byte,
    // [34:19] declared_length, [39:35] zero
  output int                       errors_o,
  output int                       pending_o
);

  import crc8frc_pkg::*;

  // verdict word as laid out in tdata, verdict in the low bits
  typedef struct packed {
    logic [15:0] length;
    logic [7:0]  sub;
    logic [7:0]  cmd;
    verdict_e    verdict;
  } verdict_word_t;

  verdict_word_t verdicts_due[$];

  // frame tracking state
  logic [15:0] length_limit;
  logic [15:0] next_pos;
  logic [15:0] len_decl;
  logic [7:0]  crc_acc;
  logic [7:0]  cmd_seen;
  logic [7:0]  sub_seen;
  logic        frame_done;

  // bitwise CRC-8 step, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  // advance the frame state by one byte; emitted is set when a verdict is due
  task automatic predict_verdict(input logic [7:0] b, input logic first,
                                 output bit emitted, output verdict_word_t w);
    emitted = 1'b0;
    w       = '0;
    if (first) begin
      next_pos   = '0;
      len_decl   = '0;
      crc_acc    = '0;
      cmd_seen   = '0;
      sub_seen   = '0;
      frame_done = 1'b0;
    end
    if (frame_done) return;

    // check byte closes the frame
    if (next_pos >= MinFrameLen && next_pos == len_decl) begin
      emitted    = 1'b1;
      frame_done = 1'b1;
      w.cmd      = cmd_seen;
      w.sub      = sub_seen;
      w.length   = len_decl;
      if (b != crc_acc) begin
        w.verdict = VERDICT_CRC_ERR;
      end else if (cmd_seen == CmdAck) begin
        w.verdict = VERDICT_ACK;
      end else if (sub_seen == SubCollectA || sub_seen == SubCollectB) begin
        w.verdict = VERDICT_COLLECT;
      end else begin
        w.verdict = VERDICT_OTHER;
      end
      return;
    end

    crc_acc = crc8_next(crc_acc, b);
    case (next_pos)
      PosLenHi: len_decl = {b, 8'h00};
      PosLenLo: begin
        len_decl[7:0] = b;
        if (len_decl > length_limit || len_decl < MinFrameLen) begin
          emitted    = 1'b1;
          frame_done = 1'b1;
          w.verdict  = VERDICT_LEN_ERR;
          w.length   = len_decl;
          return;
        end
      end
      PosCmd:   cmd_seen = b;
      PosSub:   sub_seen = b;
      default:  ;
    endcase
    next_pos = next_pos + 16'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_word_t exp_w;
    verdict_word_t got_w;
    bit            emitted;
    if (!rst_ni) begin
      length_limit = MaxLenReset;
      next_pos     = '0;
      len_decl     = '0;
      crc_acc      = '0;
      cmd_seen     = '0;
      sub_seen     = '0;
      frame_done   = 1'b1;
      verdicts_due.delete();
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) length_limit = cfg_wdata_i;

      // predict from the accepted byte word
      if (s_axis_tvalid && s_axis_tready) begin
        predict_verdict(s_axis_tdata, s_axis_tuser[0], emitted, exp_w);
        if (emitted) verdicts_due.push_back(exp_w);
      end

      // compare the accepted verdict word
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = verdict_word_t'(m_axis_tdata[34:0]);
        if (verdicts_due.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: unexpected verdict word %h", $realtime, m_axis_tdata);
          errors_o++;
        end else begin
          exp_w = verdicts_due.pop_front();
          if (got_w.verdict !== exp_w.verdict || got_w.cmd !== exp_w.cmd ||
              got_w.sub !== exp_w.sub || got_w.length !== exp_w.length ||
              m_axis_tdata[39:35] !== 5'd0) begin
            if (errors_o < 10)
              $display("%0t: mismatch exp v=%0d c=%h s=%h l=%0d, got v=%0d c=%h s=%h l=%0d p=%h",
                       $realtime, exp_w.verdict, exp_w.cmd, exp_w.sub, exp_w.length,
                       got_w.verdict, got_w.cmd, got_w.sub, got_w.length,
                       m_axis_tdata[39:35]);
            errors_o++;
          end
        end
      end
      pending_o = verdicts_due.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams into the CRC-8 frame checker: a directed set of
// frames for every verdict and corner case, then random frames under several
// length limits and back-pressure patterns. Checking is done by the
// verdict checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import crc8frc_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int StuckLimit   = 4000;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 10;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [15:0]         cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] rx_byte
  logic [0:0]          s_axis_tuser  = '0;   // [0] frame_first
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
    // [2:0] verdict, [10:3] command_byte, [18:11] subcommand_byte,
    // [34:19] declared_length, [39:35] zero

  int errors;
  int pending;

  // stimulus shaping
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_asked   = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  int          stuck_cycles  = 0;
  int          frame_words   = 0;
  logic [15:0] limit_now     = MaxLenReset;

  always #10 clk_i = ~clk_i;

  crc8_frame_receive_checker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  crc8_verdict_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      holds_done    <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // CRC-8 over one byte, used to build good check bytes
  function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    return c;
  endfunction

  // offer one byte word, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // send a frame; crc_flip corrupts the check byte, cut > 0 stops after that
  // many bytes so the next frame start abandons it
  task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
                            input logic [7:0] sub, input logic [7:0] crc_flip,
                            input int cut);
    logic [7:0] crc;
    logic [7:0] b;
    bit         whole;
    int         last;
    crc   = '0;
    whole = (len >= MinFrameLen) && (len <= limit_now);
    last  = whole ? int'(len) : 2;
    if (cut > 0 && cut <= last) last = cut - 1;
    for (int i = 0; i <= last; i++) begin
      case (i)
        1:       b = len[15:8];
        2:       b = len[7:0];
        3:       b = cmd;
        4:       b = sub;
        default: b = 8'($urandom);
      endcase
      if (whole && i == int'(len)) b = crc ^ crc_flip;
      crc = crc_after(crc, b);
      send_word(b, i == 0);
      frame_words++;
    end
  endtask

  // mostly well-formed short frames, some long, bad-length, corrupt or cut
  task automatic random_frame();
    int          r;
    int          cut;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [7:0]  sub;
    logic [7:0]  flip;
    r   = $urandom_range(99);
    cut = ($urandom_range(19) == 0) ? $urandom_range(8, 1) : 0;
    if (r < 78) begin
      len = 16'($urandom_range(24, 5));
    end else if (r < 86) begin
      len = 16'($urandom_range(300, 25));
    end else if (r < 93) begin
      len = 16'($urandom_range(4, 0));
    end else if (limit_now != 16'hFFFF) begin
      len = 16'($urandom_range(65535, int'(limit_now) + 1));
    end else begin
      // any length passes; abandon it early so it stays short
      len = 16'($urandom);
      cut = $urandom_range(12, 4);
    end
    if ($urandom_range(3) == 0) cmd = CmdAck;
    else cmd = 8'($urandom);
    r = $urandom_range(9);
    if (r < 2) sub = SubCollectA;
    else if (r == 2) sub = SubCollectB;
    else sub = 8'($urandom);
    flip = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
    send_frame(len, cmd, sub, flip, cut);
    // stray bytes between frames
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) send_word(8'($urandom), 1'b0);
    end
  endtask

  // new length limit once idle, then random frames under the given idling
  task automatic run_phase(input logic [15:0] limit, input int s_pct, input int r_pct,
                           input int words, input bit pressure);
    bit paused;
    paused = 1'b0;
    // one edge first so the count includes the last accepted byte
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    limit_now     = limit;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    if (pressure) holds_asked <= holds_asked + 1;
    frame_words = 0;
    while (frame_words < words) begin
      random_frame();
      // drain every pending verdict once mid-phase
      if (pressure && !paused && frame_words >= words / 2) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset limit
    send_idle_pct = 20;
    recv_idle_pct <= 49;
    send_word(8'hFF, 1'b0);                                // no frame started yet
    send_frame(16'd4, 8'h00, 8'h00, 8'h00, 0);             // too short
    send_frame(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 0);          // above the limit
    send_frame(16'd5, CmdAck, SubCollectA, 8'h00, 0);      // ack beats collect
    send_frame(16'd9, 8'h00, SubCollectB, 8'h00, 3);       // restarted mid-frame
    send_frame(16'd5, 8'h00, SubCollectB, 8'h00, 0);       // collect
    send_frame(16'd5, 8'hFF, 8'hFF, 8'h00, 0);             // other valid
    send_frame(16'd6, 8'h12, SubCollectA, 8'h80, 0);       // bad CRC keeps fields
    send_word(8'h00, 1'b0);                                // after a verdict
    s_axis_tvalid <= 1'b0;

    run_phase(16'hFFFF, 20, 49, 200, 1'b1);
    run_phase(16'd0, 49, 20, 60, 1'b0);
    run_phase(16'd5, 49, 20, 100, 1'b0);
    run_phase(16'($urandom_range(300, 6)), 0, 0, 250, 1'b1);

    @(posedge clk_i);
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
